FILE: hdl/pas_pkg.sv
// Package for the polyline angle simplifier.
// Holds the shared constants and the control structs between the top level
// and the sharpness unit. Depends on nothing.
package pas_pkg;

  // Default geometry of the design
  localparam int DEF_COORD_BITS = 24;
  localparam int DEF_MAX_VERTS  = 4096;

  // Width of the position field of a result
  localparam int POS_BITS = 12;

  // Threshold register, signed Q1.14, and its reset value of -1.0
  localparam int MS_BITS = 16;
  localparam logic signed [MS_BITS-1:0] MS_RESET = -16'sd16384;

  // Number of fraction bits of the squared threshold (2 x 14)
  localparam int FRAC_SHIFT = 28;

  // Configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int PADDR_BITS    = 3;
  localparam logic REG_MIN_SHARP = 1'b0;

  // Request to the sharpness unit
  typedef struct packed {
    logic start;
    logic strict;
  } pas_req_t;

  // Answer of the sharpness unit
  typedef struct packed {
    logic done;
    logic result;
  } pas_rsp_t;

endpackage

FILE: hdl/pas_in_if.sv
// Vertex input channel of the polyline angle simplifier.
// Carries valid, ready and one vertex; uses no package.
interface pas_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic                         end_of_line;

  modport source (output valid, vert_x, vert_y, end_of_line, input ready);
  modport sink   (input valid, vert_x, vert_y, end_of_line, output ready);
endinterface

FILE: hdl/pas_out_if.sv
// Result channel of the polyline angle simplifier.
// Carries valid, ready and one reduced vertex; uses no package.
interface pas_out_if #(
  parameter int COORD_BITS = 24,
  parameter int POS_BITS   = 12
);
  logic                         valid;
  logic                         ready;
  logic [POS_BITS-1:0]          position;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         final_vertex;

  modport source (output valid, position, out_x, out_y, final_vertex, input ready);
  modport sink   (input valid, position, out_x, out_y, final_vertex, output ready);
endinterface

FILE: hdl/pas_sharp.sv
// Exact sharpness test for the polyline angle simplifier.
// One shift-add multiplier is reused under a small sequencer.
// Depends on pas_pkg.
module pas_sharp #(
  parameter int COORD_BITS = pas_pkg::DEF_COORD_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pas_pkg::pas_req_t                    req_i,
  input  logic signed [COORD_BITS-1:0]         a_x_i,
  input  logic signed [COORD_BITS-1:0]         a_y_i,
  input  logic signed [COORD_BITS-1:0]         b_x_i,
  input  logic signed [COORD_BITS-1:0]         b_y_i,
  input  logic signed [COORD_BITS-1:0]         c_x_i,
  input  logic signed [COORD_BITS-1:0]         c_y_i,
  input  logic signed [pas_pkg::MS_BITS-1:0]   m_i,
  output pas_pkg::pas_rsp_t                    rsp_o
);
  import pas_pkg::*;

  // Difference, product, sum and accumulator widths
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int ACCW = 2 * SW + 32;
  localparam int CW   = $clog2(SW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ZERO, S_LOAD, S_MUL, S_SIGN, S_CMP
  } state_e;

  // Multiplications in the order they are run
  typedef enum logic [3:0] {
    OP_UXWX, OP_UYWY, OP_DD, OP_UXUX, OP_UYUY,
    OP_WXWX, OP_WYWY, OP_MM, OP_MU, OP_MW
  } op_e;

  state_e                  state_q;
  op_e                     op_q;
  logic [CW-1:0]           cnt_q;
  logic                    strict_q;
  logic signed [MS_BITS-1:0] m_q;
  logic signed [DW-1:0]    ux_q, uy_q, wx_q, wy_q;
  logic [PW-1:0]           p1_q, p2_q;
  logic [SW-1:0]           d_q, u2_q, w2_q;
  logic [2*SW-1:0]         lhs_q;
  logic [ACCW-1:0]         tmp_q;
  logic [ACCW-1:0]         ma_q, acc_q;
  logic [SW-1:0]           mb_q;
  pas_rsp_t                rsp_q;

  logic [ACCW-1:0]         load_a, acc_nx, lhs_ext;
  logic [SW-1:0]           load_b, d_c;
  logic                    keep_acc, n1, n2, neg_c, zero_c, m_zero, m_pos;
  logic [MS_BITS-1:0]      m_abs;

  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // Operand selection for the next multiplication
  always_comb begin
    m_abs    = m_q[MS_BITS-1] ? MS_BITS'(-m_q) : MS_BITS'(m_q);
    keep_acc = (op_q == OP_UYUY) || (op_q == OP_WYWY);
    case (op_q)
      OP_UXWX: begin load_a = ACCW'(mag(ux_q)); load_b = SW'(mag(wx_q)); end
      OP_UYWY: begin load_a = ACCW'(mag(uy_q)); load_b = SW'(mag(wy_q)); end
      OP_DD:   begin load_a = ACCW'(d_q);       load_b = d_q;             end
      OP_UXUX: begin load_a = ACCW'(mag(ux_q)); load_b = SW'(mag(ux_q)); end
      OP_UYUY: begin load_a = ACCW'(mag(uy_q)); load_b = SW'(mag(uy_q)); end
      OP_WXWX: begin load_a = ACCW'(mag(wx_q)); load_b = SW'(mag(wx_q)); end
      OP_WYWY: begin load_a = ACCW'(mag(wy_q)); load_b = SW'(mag(wy_q)); end
      OP_MM:   begin load_a = ACCW'(m_abs);     load_b = SW'(m_abs);     end
      OP_MU:   begin load_a = tmp_q;            load_b = u2_q;           end
      OP_MW:   begin load_a = tmp_q;            load_b = w2_q;           end
      default: begin load_a = '0;               load_b = '0;             end
    endcase
  end

  // One shift-add step of the multiplier
  assign acc_nx = mb_q[0] ? acc_q + ma_q : acc_q;

  // Signed dot product from the two magnitude products
  always_comb begin
    n1 = ux_q[DW-1] ^ wx_q[DW-1];
    n2 = uy_q[DW-1] ^ wy_q[DW-1];
    if (n1 == n2) begin
      d_c   = SW'(p1_q) + SW'(p2_q);
      neg_c = n1;
    end else if (p1_q >= p2_q) begin
      d_c   = SW'(p1_q - p2_q);
      neg_c = n1;
    end else begin
      d_c   = SW'(p2_q - p1_q);
      neg_c = n2;
    end
    zero_c  = (d_c == '0);
    m_zero  = (m_q == '0);
    m_pos   = !m_q[MS_BITS-1] && !m_zero;
    lhs_ext = ACCW'({lhs_q, {FRAC_SHIFT{1'b0}}});
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_UXWX;
      cnt_q    <= '0;
      strict_q <= 1'b0;
      m_q      <= '0;
      ux_q     <= '0;
      uy_q     <= '0;
      wx_q     <= '0;
      wy_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
      d_q      <= '0;
      u2_q     <= '0;
      w2_q     <= '0;
      lhs_q    <= '0;
      tmp_q    <= '0;
      ma_q     <= '0;
      mb_q     <= '0;
      acc_q    <= '0;
      rsp_q    <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            ux_q     <= DW'(a_x_i) - DW'(b_x_i);
            uy_q     <= DW'(a_y_i) - DW'(b_y_i);
            wx_q     <= DW'(c_x_i) - DW'(b_x_i);
            wy_q     <= DW'(c_y_i) - DW'(b_y_i);
            m_q      <= m_i;
            strict_q <= req_i.strict;
            state_q  <= S_ZERO;
          end
        end
        // A zero vector gives sharpness 0
        S_ZERO: begin
          if ((ux_q == '0 && uy_q == '0) || (wx_q == '0 && wy_q == '0)) begin
            rsp_q.done   <= 1'b1;
            rsp_q.result <= strict_q ? m_pos : (m_pos || m_zero);
            state_q      <= S_IDLE;
          end else begin
            op_q    <= OP_UXWX;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          ma_q  <= load_a;
          mb_q  <= load_b;
          cnt_q <= '0;
          if (!keep_acc) begin
            acc_q <= '0;
          end
          state_q <= S_MUL;
        end
        S_MUL: begin
          acc_q <= acc_nx;
          ma_q  <= ma_q << 1;
          mb_q  <= mb_q >> 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(SW - 1)) begin
            case (op_q)
              OP_UXWX: p1_q  <= PW'(acc_nx);
              OP_UYWY: p2_q  <= PW'(acc_nx);
              OP_DD:   lhs_q <= (2*SW)'(acc_nx);
              OP_UYUY: u2_q  <= SW'(acc_nx);
              OP_WYWY: w2_q  <= SW'(acc_nx);
              OP_MM:   tmp_q <= acc_nx;
              OP_MU:   tmp_q <= acc_nx;
              OP_MW:   tmp_q <= acc_nx;
              default: ;
            endcase
            if (op_q == OP_UYWY) begin
              state_q <= S_SIGN;
            end else if (op_q == OP_MW) begin
              state_q <= S_CMP;
            end else begin
              op_q    <= op_e'(op_q + 4'd1);
              state_q <= S_LOAD;
            end
          end
        end
        // Sign of the dot product settles m = 0, and any case where it is zero or opposite to m, without squares
        S_SIGN: begin
          d_q <= d_c;
          if (m_zero) begin
            rsp_q.done   <= 1'b1;
            rsp_q.result <= strict_q ? (!zero_c && neg_c) : (zero_c || neg_c);
            state_q      <= S_IDLE;
          end else if (m_pos && (zero_c || neg_c)) begin
            rsp_q.done   <= 1'b1;
            rsp_q.result <= 1'b1;
            state_q      <= S_IDLE;
          end else if (!m_pos && (zero_c || !neg_c)) begin
            rsp_q.done   <= 1'b1;
            rsp_q.result <= 1'b0;
            state_q      <= S_IDLE;
          end else begin
            op_q    <= OP_DD;
            state_q <= S_LOAD;
          end
        end
        // Compare d^2 * 2^28 with m^2 * |u|^2 * |w|^2
        S_CMP: begin
          rsp_q.done <= 1'b1;
          if (m_pos) begin
            rsp_q.result <= strict_q ? (lhs_ext < tmp_q) : (lhs_ext <= tmp_q);
          end else begin
            rsp_q.result <= strict_q ? (lhs_ext > tmp_q) : (lhs_ext >= tmp_q);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == S_IDLE)
    else $error("sharpness test started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.done |=> !rsp_q.done)
    else $error("sharpness answer held for more than one cycle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> cnt_q < CW'(SW))
    else $error("multiplier step count out of range");

endmodule

FILE: hdl/polyline_angle_simplifier_core.sv
// Top level of the polyline angle simplifier.
// Holds the vertex bookkeeping, the result queue and the threshold register.
// Depends on pas_pkg, pas_in_if, pas_out_if and pas_sharp.
//
//  channel  direction  transfer carries
//  in_i     sink       vert_x, vert_y, end_of_line
//  out_o    source     position, out_x, out_y, final_vertex
//  apb      slave      min_sharp at byte address 0
//
// The first two vertices of a polyline are stored without a sharpness test.
// A later vertex runs the sharpness test, which ends early for a zero vector or when
// the sign of the dot product decides, and otherwise goes on to the squares.
// The shift-add multiplier works through one multiplier bit per cycle.
// A closed polyline runs the test once more at its last vertex.
// Up to four results are queued; the input is held off while more than two wait.
module polyline_angle_simplifier_core #(
  parameter int COORD_BITS = pas_pkg::DEF_COORD_BITS,
  parameter int MAX_VERTS  = pas_pkg::DEF_MAX_VERTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pas_in_if.sink                              in_i,
  pas_out_if.source                           out_o,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [pas_pkg::PADDR_BITS-1:0]      paddr_i,
  input  logic [pas_pkg::APB_DATA_BITS-1:0]   pwdata_i,
  output logic [pas_pkg::APB_DATA_BITS-1:0]   prdata_o,
  output logic                                pready_o
);
  import pas_pkg::*;

  localparam int RCW = $clog2(MAX_VERTS + 1);

  typedef enum logic [1:0] {T_IDLE, T_TEST, T_END, T_CLOSE} state_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  state_e             state_q;
  logic [1:0]         ic_q;
  logic [RCW-1:0]     rc_q;
  logic signed [MS_BITS-1:0] min_sharp_q;
  coord_t             first_x_q, first_y_q, anchor_x_q, anchor_y_q;
  coord_t             second_x_q, second_y_q, prev_x_q, prev_y_q;
  coord_t             tail_x_q, tail_y_q, cur_x_q, cur_y_q;
  logic               cur_eol_q;

  // Result queue
  logic [POS_BITS-1:0] q_pos_q [4];
  coord_t              q_x_q   [4];
  coord_t              q_y_q   [4];
  logic                q_fin_q [4];
  logic [1:0]          wr_ptr_q, rd_ptr_q;
  logic [2:0]          q_cnt_q;

  logic                in_acc, pop, closed;
  logic                push_en, push_fin;
  logic [POS_BITS-1:0] push_pos, pos_tail;
  coord_t              push_x, push_y, b_x, b_y, c_x, c_y;
  pas_req_t            req;
  pas_rsp_t            rsp;

  function automatic logic [POS_BITS-1:0] pos_of(logic [RCW-1:0] rc);
    logic [31:0] p;
    p = 32'(rc) - 32'd1;
    return p[POS_BITS-1:0];
  endfunction

  // Configuration port
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_MIN_SHARP) ? APB_DATA_BITS'(min_sharp_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sharp_q <= MS_RESET;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == REG_MIN_SHARP) begin
      min_sharp_q <= pwdata_i[MS_BITS-1:0];
    end
  end

  // Handshakes
  assign in_i.ready = (state_q == T_IDLE) && (q_cnt_q <= 3'd2);
  assign in_acc     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;
  assign closed     = (first_x_q == cur_x_q) && (first_y_q == cur_y_q);
  assign pos_tail   = pos_of(rc_q);

  // Operands of the sharpness test: a running vertex or the wrap at vertex 0
  always_comb begin
    if (state_q == T_END) begin
      b_x = anchor_x_q;  b_y = anchor_y_q;
      c_x = second_x_q;  c_y = second_y_q;
    end else begin
      b_x = tail_x_q;    b_y = tail_y_q;
      c_x = in_i.vert_x; c_y = in_i.vert_y;
    end
    req.start  = (in_acc && ic_q == 2'd2) || (state_q == T_END && cur_eol_q && closed);
    req.strict = (state_q == T_END);
  end

  pas_sharp #(
    .COORD_BITS (COORD_BITS)
  ) u_sharp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_x_i  (prev_x_q),
    .a_y_i  (prev_y_q),
    .b_x_i  (b_x),
    .b_y_i  (b_y),
    .c_x_i  (c_x),
    .c_y_i  (c_y),
    .m_i    (min_sharp_q),
    .rsp_o  (rsp)
  );

  // Which result, if any, enters the queue this cycle
  always_comb begin
    push_en  = 1'b0;
    push_pos = pos_tail;
    push_x   = tail_x_q;
    push_y   = tail_y_q;
    push_fin = 1'b1;
    case (state_q)
      T_IDLE: begin
        if (in_acc && ic_q == 2'd0) begin
          push_en  = 1'b1;
          push_pos = '0;
          push_x   = in_i.vert_x;
          push_y   = in_i.vert_y;
          push_fin = in_i.end_of_line;
        end
      end
      T_TEST: begin
        if (rsp.done && !rsp.result) begin
          push_en  = 1'b1;
          push_fin = 1'b0;
        end
      end
      T_END: begin
        push_en = cur_eol_q && !closed;
      end
      T_CLOSE: begin
        if (rsp.done) begin
          push_en = 1'b1;
          if (rsp.result) begin
            push_pos = '0;
            push_x   = prev_x_q;
            push_y   = prev_y_q;
          end
        end
      end
      default: push_en = 1'b0;
    endcase
  end

  // Vertex bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      ic_q       <= '0;
      rc_q       <= '0;
      first_x_q  <= '0;  first_y_q  <= '0;
      anchor_x_q <= '0;  anchor_y_q <= '0;
      second_x_q <= '0;  second_y_q <= '0;
      prev_x_q   <= '0;  prev_y_q   <= '0;
      tail_x_q   <= '0;  tail_y_q   <= '0;
      cur_x_q    <= '0;  cur_y_q    <= '0;
      cur_eol_q  <= 1'b0;
    end else begin
      case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            cur_x_q   <= in_i.vert_x;
            cur_y_q   <= in_i.vert_y;
            cur_eol_q <= in_i.end_of_line;
            case (ic_q)
              2'd0: begin
                first_x_q  <= in_i.vert_x;  first_y_q  <= in_i.vert_y;
                anchor_x_q <= in_i.vert_x;  anchor_y_q <= in_i.vert_y;
                prev_x_q   <= in_i.vert_x;  prev_y_q   <= in_i.vert_y;
                tail_x_q   <= in_i.vert_x;  tail_y_q   <= in_i.vert_y;
                ic_q       <= in_i.end_of_line ? 2'd0 : 2'd1;
                rc_q       <= in_i.end_of_line ? '0 : RCW'(1);
              end
              2'd1: begin
                prev_x_q   <= anchor_x_q;   prev_y_q   <= anchor_y_q;
                second_x_q <= in_i.vert_x;  second_y_q <= in_i.vert_y;
                tail_x_q   <= in_i.vert_x;  tail_y_q   <= in_i.vert_y;
                rc_q       <= RCW'(2);
                ic_q       <= 2'd2;
                state_q    <= T_END;
              end
              default: state_q <= T_TEST;
            endcase
          end
        end
        // Merge into the tail, or keep the tail and start a new one
        T_TEST: begin
          if (rsp.done) begin
            tail_x_q <= cur_x_q;
            tail_y_q <= cur_y_q;
            if (rsp.result) begin
              if (rc_q == RCW'(2)) begin
                second_x_q <= cur_x_q;
                second_y_q <= cur_y_q;
              end
            end else begin
              prev_x_q <= tail_x_q;
              prev_y_q <= tail_y_q;
              if (rc_q < RCW'(MAX_VERTS)) begin
                rc_q <= rc_q + 1'b1;
              end
            end
            state_q <= T_END;
          end
        end
        T_END: begin
          if (!cur_eol_q) begin
            state_q <= T_IDLE;
          end else if (closed) begin
            state_q <= T_CLOSE;
          end else begin
            ic_q    <= '0;
            rc_q    <= '0;
            state_q <= T_IDLE;
          end
        end
        T_CLOSE: begin
          if (rsp.done) begin
            ic_q    <= '0;
            rc_q    <= '0;
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // Result queue, four entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_en && !pop) begin
        q_cnt_q <= q_cnt_q + 1'b1;
      end else if (pop && !push_en) begin
        q_cnt_q <= q_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      q_pos_q[wr_ptr_q] <= push_pos;
      q_x_q[wr_ptr_q]   <= push_x;
      q_y_q[wr_ptr_q]   <= push_y;
      q_fin_q[wr_ptr_q] <= push_fin;
    end
  end

  assign out_o.valid        = (q_cnt_q != 3'd0);
  assign out_o.position     = q_pos_q[rd_ptr_q];
  assign out_o.out_x        = q_x_q[rd_ptr_q];
  assign out_o.out_y        = q_y_q[rd_ptr_q];
  assign out_o.final_vertex = q_fin_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |-> q_cnt_q < 3'd4)
    else $error("result queue overflow");

  a_answer_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == T_TEST || state_q == T_CLOSE))
    else $error("sharpness answer arrived unexpectedly");

  a_single_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ic_q == 2'd0 && in_i.end_of_line) |=> (ic_q == 2'd0 && rc_q == '0))
    else $error("single-vertex polyline left state behind");

endmodule
